@@ src/stereo_audio_frame_fifo_macros.svh @@
// Assertion macros shared by the checks of the frame FIFO checker.
`ifndef STEREO_AUDIO_FRAME_FIFO_MACROS_SVH
`define STEREO_AUDIO_FRAME_FIFO_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define SAFF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: same-cycle check failed");

// Next-cycle implication, masked while reset is high.
`define SAFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SAFF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ src/saff_pkg.sv @@
// Shared types, widths and codes of the stereo audio frame FIFO.
package saff_pkg;

   localparam int RING_DEPTH_DEF = 1024;
   localparam int MAX_BURST_DEF  = 64;

   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int REQ_W    = 2;
   localparam int WANT_W   = 7;
   localparam int FILL_W   = 11;
   localparam int CHAN_W   = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SOURCE_CHANNELS = '0;
   localparam logic [CHAN_W-1:0]    CHAN_MONO   = 2'd1;
   localparam logic [CHAN_W-1:0]    CHAN_STEREO = 2'd2;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH  = 2'd0,
      REQ_PULL  = 2'd1,
      REQ_EOS   = 2'd2,
      REQ_FLUSH = 2'd3
   } req_code_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } fsm_state_type;

   typedef struct packed {
      logic capture;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic final_beat;
   } ctrl_sts_type;

endpackage

@@ src/saff_if.sv @@
// Valid/ready channel interfaces for requests and results.
interface saff_req_if
   import saff_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic [REQ_W-1:0]           req_type;
   logic signed [SAMPLE_W-1:0] sample_left;
   logic signed [SAMPLE_W-1:0] sample_right;
   logic [WANT_W-1:0]          frames_wanted;

   modport source (output valid, output req_type, output sample_left,
                   output sample_right, output frames_wanted, input ready);
   modport sink   (input valid, input req_type, input sample_left,
                   input sample_right, input frames_wanted, output ready);
endinterface

interface saff_rsp_if
   import saff_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_left;
   logic signed [SAMPLE_W-1:0] out_right;
   logic                       frame_valid;
   logic                       last;
   logic                       accepted;
   logic [FILL_W-1:0]          fill_level;
   logic                       stream_ended;

   modport source (output valid, output out_left, output out_right,
                   output frame_valid, output last, output accepted,
                   output fill_level, output stream_ended, input ready);
   modport sink   (input valid, input out_left, input out_right,
                   input frame_valid, input last, input accepted,
                   input fill_level, input stream_ended, output ready);
endinterface

@@ src/saff_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module saff_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/saff_datapath.sv @@
// Ring counters, end flag, request holding registers and result register.
module saff_datapath
   import saff_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int MAX_BURST  = MAX_BURST_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctrl_cmd_type               cmd,
   output ctrl_sts_type               sts,
   input  logic                       mono,
   input  logic [REQ_W-1:0]           req_code,
   input  logic signed [SAMPLE_W-1:0] req_left,
   input  logic signed [SAMPLE_W-1:0] req_right,
   input  logic [WANT_W-1:0]          req_wanted,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic signed [SAMPLE_W-1:0] rsp_left,
   output logic signed [SAMPLE_W-1:0] rsp_right,
   output logic                       rsp_frame_valid,
   output logic                       rsp_last,
   output logic                       rsp_accepted,
   output logic [FILL_W-1:0]          rsp_fill_level,
   output logic                       rsp_stream_ended
);

   localparam int SPAN   = 2 * RING_DEPTH;
   localparam int CNT_W  = $clog2(SPAN);
   localparam int ADDR_W = $clog2(RING_DEPTH);
   localparam int CMP_W  = (CNT_W > WANT_W) ? CNT_W : WANT_W;

   localparam logic [CNT_W-1:0]  DEPTH_C    = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0]  CNT_TOP    = CNT_W'(SPAN - 1);
   localparam logic [CNT_W:0]    SPAN_C     = (CNT_W + 1)'(SPAN);
   localparam logic [WANT_W-1:0] MAX_BURST_C = WANT_W'(MAX_BURST);

   // count advance modulo twice the depth
   function automatic logic [CNT_W-1:0] count_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_TOP) ? '0 : c + 1'b1;
   endfunction

   // ring slot of a count
   function automatic logic [ADDR_W-1:0] slot_of(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] s;
      s = (c >= DEPTH_C) ? c - DEPTH_C : c;
      return s[ADDR_W-1:0];
   endfunction

   // frames held, difference of the counts modulo twice the depth
   function automatic logic [CNT_W-1:0] fill_of(input logic [CNT_W-1:0] w,
                                                input logic [CNT_W-1:0] r);
      logic [CNT_W:0] d;
      d = {1'b0, w} - {1'b0, r};
      if (w < r) begin
         d = d + SPAN_C;
      end
      return d[CNT_W-1:0];
   endfunction

   logic [CNT_W-1:0]  wc_ff, wc_in;
   logic [CNT_W-1:0]  rc_ff, rc_in;
   logic              end_ff, end_in;
   req_code_type      op_ff, op_in;
   logic [SAMPLE_W-1:0] left_ff, left_in;
   logic [SAMPLE_W-1:0] right_ff, right_in;
   logic [WANT_W-1:0] burst_ff, burst_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] out_left_ff, out_left_in;
   logic [SAMPLE_W-1:0] out_right_ff, out_right_in;
   logic                fvalid_ff, fvalid_in;
   logic                last_ff, last_in;
   logic                acc_ff, acc_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                ended_ff, ended_in;

   logic [CNT_W-1:0]  fill_now;
   logic [CNT_W-1:0]  fill_after;
   logic              push_ok;
   logic [WANT_W-1:0] clip;
   logic [WANT_W-1:0] burst_len;
   logic              ram_we;
   logic [FRAME_W-1:0] rd_data;

   assign fill_now = fill_of(wc_ff, rc_ff);
   assign push_ok  = !end_ff && (fill_now < DEPTH_C);

   // cut a pull to the burst limit and to the frames held
   assign clip      = (req_wanted > MAX_BURST_C) ? MAX_BURST_C : req_wanted;
   assign burst_len = (CMP_W'(fill_now) < CMP_W'(clip)) ? WANT_W'(fill_now) : clip;

   // hold the request fields on capture
   always_comb begin
      op_in    = op_ff;
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd.capture) begin
         op_in    = req_code_type'(req_code);
         left_in  = req_left;
         right_in = mono ? req_left : req_right;
      end
   end

   // execute one beat of the held request
   always_comb begin
      wc_in        = wc_ff;
      rc_in        = rc_ff;
      end_in       = end_ff;
      burst_in     = cmd.capture ? burst_len : burst_ff;
      ram_we       = 1'b0;
      out_left_in  = '0;
      out_right_in = '0;
      fvalid_in    = 1'b0;
      last_in      = 1'b1;
      acc_in       = 1'b0;
      if (cmd.step) begin
         case (op_ff)
            REQ_PUSH: begin
               if (push_ok) begin
                  ram_we = 1'b1;
                  wc_in  = count_inc(wc_ff);
                  acc_in = 1'b1;
               end
            end
            REQ_PULL: begin
               if (burst_ff != '0) begin
                  out_left_in  = rd_data[SAMPLE_W-1:0];
                  out_right_in = rd_data[FRAME_W-1:SAMPLE_W];
                  fvalid_in    = 1'b1;
                  last_in      = (burst_ff == WANT_W'(1));
                  rc_in        = count_inc(rc_ff);
                  burst_in     = burst_ff - 1'b1;
               end
            end
            REQ_EOS: begin
               end_in = 1'b1;
            end
            REQ_FLUSH: begin
               wc_in  = '0;
               rc_in  = '0;
               end_in = 1'b0;
            end
            default: begin
               end_in = end_ff;
            end
         endcase
      end
   end

   // status after the beat
   assign fill_after = fill_of(wc_in, rc_in);
   assign fill_in    = FILL_W'(fill_after);
   assign ended_in   = end_in && (fill_after == '0);

   // result register: load on a beat, drop when taken
   assign rsp_valid_in = cmd.step | (rsp_valid_ff & ~rsp_ready);

   assign sts.out_free   = !rsp_valid_ff || rsp_ready;
   assign sts.final_beat = (op_ff != REQ_PULL) || (burst_ff <= WANT_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         wc_ff        <= '0;
         rc_ff        <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wc_ff        <= wc_in;
         rc_ff        <= rc_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      burst_ff <= burst_in;
      if (cmd.step) begin
         out_left_ff  <= out_left_in;
         out_right_ff <= out_right_in;
         fvalid_ff    <= fvalid_in;
         last_ff      <= last_in;
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         ended_ff     <= ended_in;
      end
   end

   // frame store: read address follows the next read count
   saff_ram #(
      .WIDTH (FRAME_W),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_of(wc_ff)),
      .wr_data ({right_ff, left_ff}),
      .rd_addr (slot_of(rc_in)),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left         = out_left_ff;
   assign rsp_right        = out_right_ff;
   assign rsp_frame_valid  = fvalid_ff;
   assign rsp_last         = last_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_fill_level   = fill_ff;
   assign rsp_stream_ended = ended_ff;

endmodule

@@ src/saff_ctrl.sv @@
// Controller: takes one request, then steps it one beat at a time.
module saff_ctrl
   import saff_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output ctrl_cmd_type cmd,
   input  ctrl_sts_type sts
);

   fsm_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.out_free && sts.final_beat) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.step    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.step = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/stereo_audio_frame_fifo.sv @@
// Top level of the stereo audio frame FIFO: channels, register port, units.
//
// Requests arrive on req_bus (valid/ready): push a frame, pull a burst,
// mark end of stream, or flush. Results leave on rsp_bus (valid/ready);
// every request yields at least one result beat, the final one with last.
// A pull yields min(frames_wanted, MAX_BURST, fill) frame beats, oldest
// first, or a single empty beat with last when nothing can be given.
// The source_channels register sits at byte address 0 of the APB port;
// write it only while the block is idle (1 = mono, else stereo).
// A request is captured in the idle state of the controller and its beats
// are issued from the execute state, one frame a cycle for a pull while
// the result register is free; no new request is taken until the final
// beat has been issued. The registered read port of the frame store is fed
// the next read count, so each frame is ready when its beat is issued.
// A stalled result holds in the output register and the burst pauses.
// Reset empties the ring, clears the end flag and selects stereo; the
// frame store itself is not cleared and needs no pass after reset.
module stereo_audio_frame_fifo
   import saff_pkg::*;
#(
   parameter int RING_DEPTH = RING_DEPTH_DEF,
   parameter int MAX_BURST  = MAX_BURST_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   saff_req_if.sink              req_bus,
   saff_rsp_if.source            rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CHAN_W-1:0] src_ch_ff, src_ch_in;
   logic              csr_hit;
   ctrl_cmd_type      cmd;
   ctrl_sts_type      sts;

   // register decode
   assign csr_hit = (paddr[CSR_ADDR_W-1:2] == CSR_IDX_SOURCE_CHANNELS);
   assign pready  = 1'b1;

   always_comb begin
      src_ch_in = src_ch_ff;
      if (psel && penable && pwrite && csr_hit) begin
         src_ch_in = pwdata[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ch_ff <= CHAN_STEREO;
      end else begin
         src_ch_ff <= src_ch_in;
      end
   end

   assign prdata = csr_hit ? CSR_DATA_W'(src_ch_ff) : '0;

   saff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   saff_datapath #(
      .RING_DEPTH (RING_DEPTH),
      .MAX_BURST  (MAX_BURST)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .mono             (src_ch_ff == CHAN_MONO),
      .req_code         (req_bus.req_type),
      .req_left         (req_bus.sample_left),
      .req_right        (req_bus.sample_right),
      .req_wanted       (req_bus.frames_wanted),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_left         (rsp_bus.out_left),
      .rsp_right        (rsp_bus.out_right),
      .rsp_frame_valid  (rsp_bus.frame_valid),
      .rsp_last         (rsp_bus.last),
      .rsp_accepted     (rsp_bus.accepted),
      .rsp_fill_level   (rsp_bus.fill_level),
      .rsp_stream_ended (rsp_bus.stream_ended)
   );

endmodule

@@ src/saff_checker.sv @@
// Port-level checks of the frame FIFO, bound to the top level.
`include "stereo_audio_frame_fifo_macros.svh"

module saff_checker
   import saff_pkg::*;
(
   input logic        clock,
   input logic        reset,
   saff_req_if.sink   req_bus,
   saff_rsp_if.source rsp_bus
);

   // a stalled result beat stays up
   `SAFF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid)

   // a frame beat never reports a stored push
   `SAFF_ASSERT_IMPLY(a_frame_not_push, clock, reset, rsp_bus.valid && rsp_bus.frame_valid, !rsp_bus.accepted)

   // beats without a frame carry zero samples and close their request
   `SAFF_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_bus.valid && !rsp_bus.frame_valid, (rsp_bus.out_left == '0) && (rsp_bus.out_right == '0) && rsp_bus.last)

   // an ended stream has an empty ring
   `SAFF_ASSERT_IMPLY(a_ended_empty, clock, reset, rsp_bus.valid && rsp_bus.stream_ended, rsp_bus.fill_level == '0)

   // reset drops any pending result
   `SAFF_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_bus.valid)

endmodule

bind stereo_audio_frame_fifo saff_checker u_saff_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);

@@ dv/stereo_audio_frame_fifo_test.sv @@
// Self-checking testbench for the stereo audio frame FIFO: random traffic and a scoreboard.
module stereo_audio_frame_fifo_test;
   import saff_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RING        = RING_DEPTH_DEF;
   localparam int BURST       = MAX_BURST_DEF;
   localparam int STALL_LIMIT = 2000;
   localparam logic [CSR_ADDR_W-1:0] CHAN_ADDR = {CSR_IDX_SOURCE_CHANNELS, 2'b00};

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       frame_valid;
      logic                       last;
      logic                       accepted;
      logic [FILL_W-1:0]          fill_level;
      logic                       stream_ended;
   } frame_beat_type;

   // Tracks the ring contents and checks every result beat in order.
   class frame_ring_scoreboard;
      logic [FRAME_W-1:0] ring_mem [RING];
      logic [FILL_W-1:0]  wr_count;
      logic [FILL_W-1:0]  rd_count;
      logic               end_flag;
      logic [CHAN_W-1:0]  channels;
      frame_beat_type     expected_beats[$];
      int                 errors;

      function new();
         wr_count = '0;
         rd_count = '0;
         end_flag = 1'b0;
         channels = CHAN_STEREO;
         errors   = 0;
      endfunction

      function void set_channels(logic [CHAN_W-1:0] value);
         channels = value;
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      // Counts run modulo twice the depth, so an 11-bit difference is the fill.
      function int fill();
         logic [FILL_W-1:0] diff;
         diff = wr_count - rd_count;
         return int'(diff);
      endfunction

      function void flag(string msg);
         if (errors < 10)
            $display("%0t: %s", $time, msg);
         errors++;
      endfunction

      function void add_beat(logic [SAMPLE_W-1:0] left, logic [SAMPLE_W-1:0] right,
                             logic valid, logic last, logic accepted);
         frame_beat_type b;
         b.left         = left;
         b.right        = right;
         b.frame_valid  = valid;
         b.last         = last;
         b.accepted     = accepted;
         b.fill_level   = FILL_W'(fill());
         b.stream_ended = end_flag && (fill() == 0);
         expected_beats.push_back(b);
      endfunction

      // Apply one accepted request and queue the beats it produces.
      function void log_request(req_code_type code, logic [SAMPLE_W-1:0] left,
                                logic [SAMPLE_W-1:0] right, logic [WANT_W-1:0] wanted);
         int                 n;
         logic               ok;
         logic [FRAME_W-1:0] word;
         case (code)
            REQ_PUSH: begin
               ok = !end_flag && (fill() < RING);
               if (ok) begin
                  if (channels == CHAN_MONO)
                     right = left;
                  ring_mem[wr_count % RING] = {right, left};
                  wr_count++;
               end
               add_beat('0, '0, 1'b0, 1'b1, ok);
            end
            REQ_PULL: begin
               n = int'(wanted);
               if (n > BURST)
                  n = BURST;
               if (n > fill())
                  n = fill();
               if (n == 0)
                  add_beat('0, '0, 1'b0, 1'b1, 1'b0);
               for (int k = 0; k < n; k++) begin
                  word = ring_mem[rd_count % RING];
                  rd_count++;
                  add_beat(word[SAMPLE_W-1:0], word[FRAME_W-1:SAMPLE_W], 1'b1,
                           k == n - 1, 1'b0);
               end
            end
            REQ_EOS: begin
               end_flag = 1'b1;
               add_beat('0, '0, 1'b0, 1'b1, 1'b0);
            end
            default: begin
               wr_count = '0;
               rd_count = '0;
               end_flag = 1'b0;
               add_beat('0, '0, 1'b0, 1'b1, 1'b0);
            end
         endcase
      endfunction

      // Compare one received beat against the oldest expectation.
      function void check_beat(frame_beat_type got);
         frame_beat_type want;
         if (expected_beats.size() == 0) begin
            flag($sformatf("unexpected beat L=%0d R=%0d fv=%0b last=%0b acc=%0b fill=%0d end=%0b",
                           got.left, got.right, got.frame_valid, got.last, got.accepted,
                           got.fill_level, got.stream_ended));
            return;
         end
         want = expected_beats.pop_front();
         if (got.left !== want.left || got.right !== want.right ||
             got.frame_valid !== want.frame_valid || got.last !== want.last ||
             got.accepted !== want.accepted || got.fill_level !== want.fill_level ||
             got.stream_ended !== want.stream_ended)
            flag($sformatf({"beat mismatch: expected L=%0d R=%0d fv=%0b last=%0b acc=%0b ",
                            "fill=%0d end=%0b, got L=%0d R=%0d fv=%0b last=%0b acc=%0b ",
                            "fill=%0d end=%0b"},
                           want.left, want.right, want.frame_valid, want.last, want.accepted,
                           want.fill_level, want.stream_ended,
                           got.left, got.right, got.frame_valid, got.last, got.accepted,
                           got.fill_level, got.stream_ended));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   saff_req_if req_bus ();
   saff_rsp_if rsp_bus ();

   frame_ring_scoreboard board;
   bit                   steady = 1'b0;
   int                   quiet_cycles = 0;

   stereo_audio_frame_fifo dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #2 clock = ~clock;

   // Abort when no beat or register access moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("stereo_audio_frame_fifo_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Accept result beats with random stalls and check each one.
   initial begin : result_sink
      int             stall;
      frame_beat_type got;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.left         = rsp_bus.out_left;
         got.right        = rsp_bus.out_right;
         got.frame_valid  = rsp_bus.frame_valid;
         got.last         = rsp_bus.last;
         got.accepted     = rsp_bus.accepted;
         got.fill_level   = rsp_bus.fill_level;
         got.stream_ended = rsp_bus.stream_ended;
         board.check_beat(got);
      end
   end

   function automatic logic [SAMPLE_W-1:0] any_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         3:       return 16'hFFFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Mostly short bursts, some up to the burst cap, some oversized.
   function automatic logic [WANT_W-1:0] any_wanted();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '0;
      else if (r < 70)
         return WANT_W'($urandom_range(1, 12));
      else if (r < 85)
         return WANT_W'($urandom_range(13, BURST));
      else
         return WANT_W'($urandom_range(BURST + 1, 127));
   endfunction

   // Drive one request beat after a random gap and hold it until accepted.
   task automatic send_request(input req_code_type code, input logic [SAMPLE_W-1:0] left,
                               input logic [SAMPLE_W-1:0] right,
                               input logic [WANT_W-1:0] wanted);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= code;
      req_bus.sample_left   <= left;
      req_bus.sample_right  <= right;
      req_bus.frames_wanted <= wanted;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.log_request(code, left, right, wanted);
   endtask

   task automatic push(input logic [SAMPLE_W-1:0] left, input logic [SAMPLE_W-1:0] right);
      send_request(REQ_PUSH, left, right, WANT_W'($urandom));
   endtask

   task automatic pull(input logic [WANT_W-1:0] wanted);
      send_request(REQ_PULL, any_sample(), any_sample(), wanted);
   endtask

   task automatic mark(input req_code_type code);
      send_request(code, any_sample(), any_sample(), WANT_W'($urandom));
   endtask

   // Hold off the sender until every expected beat is back, then let the pipe settle.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] data,
                             output logic [CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= write;
      paddr   <= CHAN_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Write the channel mode on an idle block and read it back.
   task automatic set_channel_mode(input logic [CHAN_W-1:0] mode);
      logic [CSR_DATA_W-1:0] rdata;
      logic [CSR_DATA_W-1:0] value;
      value = CSR_DATA_W'(mode);
      wait_drained();
      csr_access(1'b1, value, rdata);
      board.set_channels(mode);
      csr_access(1'b0, '0, rdata);
      if (rdata !== value)
         board.flag($sformatf("channel register read %0h, expected %0h", rdata, value));
   endtask

   task automatic random_traffic(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 29) == 0)
            steady = !steady;
         if ($urandom_range(0, 39) == 0)
            wait_drained();
         r = $urandom_range(0, 99);
         if (r < 55)
            push(any_sample(), any_sample());
         else if (r < 85)
            pull(any_wanted());
         else if (r < 92)
            mark(REQ_EOS);
         else
            mark(REQ_FLUSH);
      end
      steady = 1'b0;
   endtask

   // Build a backlog past one burst, end the stream over it, then drain with capped bursts.
   task automatic fill_ring();
      steady = 1'b1;
      mark(REQ_FLUSH);
      for (int i = 0; i < BURST + 8; i++)
         push(any_sample(), any_sample());
      pull(7'd127);
      mark(REQ_EOS);
      push(any_sample(), any_sample());
      steady = 1'b0;
      pull(7'd65);
      pull(7'd64);
      mark(REQ_FLUSH);
      for (int i = 0; i < 4; i++)
         push(any_sample(), any_sample());
   endtask

   task automatic directed_checks();
      pull(7'd5);
      pull(7'd0);
      push(16'h7FFF, 16'h8000);
      push(16'h8000, 16'h7FFF);
      push(16'hFFFF, 16'h0000);
      push(16'h0000, 16'hFFFF);
      pull(7'd0);
      pull(7'd1);
      pull(7'd127);
      pull(7'd1);
      // end of stream on an empty ring, then refused push and empty pull
      mark(REQ_EOS);
      push(16'h1234, 16'h5678);
      pull(7'd2);
      mark(REQ_EOS);
      mark(REQ_FLUSH);
      // end of stream with frames still held
      push(16'h1234, 16'h5678);
      push(any_sample(), any_sample());
      mark(REQ_EOS);
      push(16'h4321, 16'h8765);
      pull(7'd1);
      pull(7'd5);
      mark(REQ_FLUSH);
   endtask

   initial begin
      reset                 <= 1'b1;
      psel                  <= 1'b0;
      penable               <= 1'b0;
      pwrite                <= 1'b0;
      paddr                 <= '0;
      pwdata                <= '0;
      req_bus.valid         <= 1'b0;
      req_bus.req_type      <= REQ_PUSH;
      req_bus.sample_left   <= '0;
      req_bus.sample_right  <= '0;
      req_bus.frames_wanted <= '0;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_channel_mode(CHAN_STEREO);
      directed_checks();
      set_channel_mode(CHAN_MONO);
      push(16'h1111, 16'h2222);
      pull(7'd1);
      random_traffic(65);
      set_channel_mode(2'd3);
      fill_ring();
      random_traffic(65);
      set_channel_mode(2'd0);
      random_traffic(65);
      set_channel_mode(CHAN_STEREO);
      random_traffic(65);

      wait_drained();
      repeat (20) @(posedge clock);
      board.errors += board.pending();
      if (board.errors == 0)
         $display("stereo_audio_frame_fifo_test passed");
      else
         $display("stereo_audio_frame_fifo_test failed");
      $finish;
   end

endmodule

@@ stereo_audio_frame_fifo.f @@
+incdir+src
src/saff_pkg.sv
src/saff_if.sv
src/saff_ram.sv
src/saff_datapath.sv
src/saff_ctrl.sv
src/stereo_audio_frame_fifo.sv
src/saff_checker.sv
dv/stereo_audio_frame_fifo_test.sv
